// File: rtl/qlmc_pkg.sv
// Package for the quota-limited max-quality slice arbiter.
// Holds widths, register codes, reset values and the shared types.
// No dependencies; every other file refers to it by scoped names.
package qlmc_pkg;

	localparam int SLICE_FIELDS    = 4;
	localparam int MAX_SLICE_COUNT = 4;
	localparam int COUNT_BITS      = 6;
	localparam int QUOTA_BITS      = 6;
	localparam int ACTIVE_BITS     = 3;
	localparam int QUALITY_BITS    = 4;
	localparam int WINNER_BITS     = 2;

	// Only the slices that have both a quality field and a counter take part.
	localparam int LANES = (MAX_SLICE_COUNT < SLICE_FIELDS) ? MAX_SLICE_COUNT : SLICE_FIELDS;
	localparam int CMP_BITS = (COUNT_BITS > QUOTA_BITS) ? COUNT_BITS : QUOTA_BITS;

	localparam int APB_ADDR_BITS  = 5;
	localparam int APB_DATA_BITS  = 32;
	localparam int REG_IDX_BITS   = 3;
	localparam int TDATA_IN_BITS  = SLICE_FIELDS * QUALITY_BITS;
	localparam int TDATA_OUT_BITS = 8;

	localparam logic [REG_IDX_BITS-1:0] REG_ACTIVE = 3'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_QUOTA0 = 3'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_QUOTA1 = 3'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_QUOTA2 = 3'd3;
	localparam logic [REG_IDX_BITS-1:0] REG_QUOTA3 = 3'd4;

	localparam logic CMD_CLEAR = 1'b0;
	localparam logic CMD_ALLOC = 1'b1;

	localparam logic [ACTIVE_BITS-1:0] ACTIVE_RESET = 3'd4;
	localparam logic [QUOTA_BITS-1:0]  QUOTA_RESET  = 6'd8;

	typedef logic [COUNT_BITS-1:0]   count_t;
	typedef logic [QUOTA_BITS-1:0]   quota_t;
	typedef logic [QUALITY_BITS-1:0] quality_t;

	typedef count_t   [LANES-1:0]        count_vec_t;
	typedef quality_t [SLICE_FIELDS-1:0] quality_vec_t;

	typedef struct packed {
		logic [ACTIVE_BITS-1:0]      active_slices;
		quota_t [SLICE_FIELDS-1:0]   quota;
	} cfg_t;

	typedef struct packed {
		logic                   found;
		logic [WINNER_BITS-1:0] winner;
		logic [LANES-1:0]       grant;
	} pick_t;

endpackage

// File: rtl/qlmc_cfg_regs.sv
// Configuration registers of the slice arbiter behind an APB-style port.
// Depends on qlmc_pkg for register codes, widths and reset values.
module qlmc_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [qlmc_pkg::APB_ADDR_BITS-1:0] paddr,
	input  logic [qlmc_pkg::APB_DATA_BITS-1:0] pwdata,
	output logic [qlmc_pkg::APB_DATA_BITS-1:0] prdata,
	output logic                               pready,
	output qlmc_pkg::cfg_t                     cfg
);

	qlmc_pkg::cfg_t                       cfg_q;
	logic [qlmc_pkg::REG_IDX_BITS-1:0]    reg_idx;
	logic                                 wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[qlmc_pkg::APB_ADDR_BITS-1:2];
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_slices <= qlmc_pkg::ACTIVE_RESET;
			for (int i = 0; i < qlmc_pkg::SLICE_FIELDS; i++) begin
				cfg_q.quota[i] <= qlmc_pkg::QUOTA_RESET;
			end
		end else if (wr_en) begin
			unique case (reg_idx)
				qlmc_pkg::REG_ACTIVE: begin
					cfg_q.active_slices <= pwdata[qlmc_pkg::ACTIVE_BITS-1:0];
				end
				qlmc_pkg::REG_QUOTA0: begin
					cfg_q.quota[0] <= pwdata[qlmc_pkg::QUOTA_BITS-1:0];
				end
				qlmc_pkg::REG_QUOTA1: begin
					cfg_q.quota[1] <= pwdata[qlmc_pkg::QUOTA_BITS-1:0];
				end
				qlmc_pkg::REG_QUOTA2: begin
					cfg_q.quota[2] <= pwdata[qlmc_pkg::QUOTA_BITS-1:0];
				end
				qlmc_pkg::REG_QUOTA3: begin
					cfg_q.quota[3] <= pwdata[qlmc_pkg::QUOTA_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			qlmc_pkg::REG_ACTIVE: prdata = qlmc_pkg::APB_DATA_BITS'(cfg_q.active_slices);
			qlmc_pkg::REG_QUOTA0: prdata = qlmc_pkg::APB_DATA_BITS'(cfg_q.quota[0]);
			qlmc_pkg::REG_QUOTA1: prdata = qlmc_pkg::APB_DATA_BITS'(cfg_q.quota[1]);
			qlmc_pkg::REG_QUOTA2: prdata = qlmc_pkg::APB_DATA_BITS'(cfg_q.quota[2]);
			qlmc_pkg::REG_QUOTA3: prdata = qlmc_pkg::APB_DATA_BITS'(cfg_q.quota[3]);
			default:              prdata = '0;
		endcase
	end

endmodule

// File: rtl/qlmc_pick.sv
// Winner selection of the slice arbiter: eligibility and max-quality search.
// Depends on qlmc_pkg for the configuration, count and result types.
module qlmc_pick (
	input  qlmc_pkg::cfg_t         cfg,
	input  qlmc_pkg::count_vec_t   counts,
	input  qlmc_pkg::quality_vec_t quality,
	output qlmc_pkg::pick_t        pick
);

	always_comb begin
		logic                    elig;
		qlmc_pkg::quality_t      best_q;
		best_q = '0;
		pick   = '0;
		// Scanning upwards with >= lets the highest index win on a tie.
		for (int i = 0; i < qlmc_pkg::LANES; i++) begin
			elig = (qlmc_pkg::ACTIVE_BITS'(i) < cfg.active_slices)
				&& (qlmc_pkg::CMP_BITS'(counts[i]) < qlmc_pkg::CMP_BITS'(cfg.quota[i]));
			if (elig && (!pick.found || quality[i] >= best_q)) begin
				best_q      = quality[i];
				pick.found  = 1'b1;
				pick.winner = qlmc_pkg::WINNER_BITS'(i);
				pick.grant  = '0;
				pick.grant[i] = 1'b1;
			end
		end
	end

endmodule

// File: rtl/quota_limited_max_cqi_slice_arbiter.sv
// Top level of the quota-limited max-quality slice arbiter.
// Instantiates qlmc_cfg_regs and qlmc_pick; uses qlmc_pkg for types and constants.
//
// Usage
//  The slave stream carries one command word per resource block group. s_tuser is the
//  command: clear starts a new interval and zeroes every grant count, allocate grants
//  the block to the eligible active slice of highest quality (highest index on a tie).
//  s_tdata carries the four slice qualities, four bits each.
//  The master stream returns one result word per command word: m_tdata holds the
//  winning slice index and m_tuser flags that no active slice was below its quota.
//  A clear returns slice zero with the flag low; a refused allocation changes nothing.
//  From acceptance to m_tvalid the word is first held in an input register, then
//  the decision and the count update happen together as the result register loads.
//  One word is accepted per cycle, sustained, while m_tready stays high; the count
//  registers feed the selection logic directly, so back-to-back allocations always
//  see the counts left by the word before.
//  When the receiver stalls, the result register holds its word and the input
//  register still takes one more word; after that s_tready falls until m_tready rises.
//  Reset clears the counts and both valid bits and loads the register reset values
//  (all four slices active, quota eight each). Configuration must be written over the
//  APB-style port only while the stream is idle, which the block does not enforce; pready is always high.
module quota_limited_max_cqi_slice_arbiter (
	input  logic                                clk,
	input  logic                                arst_n,
	// APB-style configuration port.
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [qlmc_pkg::APB_ADDR_BITS-1:0]  paddr,
	input  logic [qlmc_pkg::APB_DATA_BITS-1:0]  pwdata,
	output logic [qlmc_pkg::APB_DATA_BITS-1:0]  prdata,
	output logic                                pready,
	// Slave stream.
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// s_tdata: quality_slice0 [3:0], quality_slice1 [7:4], quality_slice2 [11:8],
	// quality_slice3 [15:12].
	input  logic [qlmc_pkg::TDATA_IN_BITS-1:0]  s_tdata,
	// s_tuser: cmd [0].
	input  logic                                s_tuser,
	// Master stream.
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// m_tdata: winner_slice [1:0], zero fill [7:2].
	output logic [qlmc_pkg::TDATA_OUT_BITS-1:0] m_tdata,
	// m_tuser: none_eligible [0].
	output logic                                m_tuser
);

	qlmc_pkg::cfg_t         cfg;
	qlmc_pkg::pick_t        pick;
	qlmc_pkg::quality_vec_t quality_in;
	qlmc_pkg::quality_vec_t quality_s1;
	qlmc_pkg::count_vec_t   count_q;
	logic                   valid_s1;
	logic                   cmd_s1;
	logic                   out_valid_q;
	logic [qlmc_pkg::WINNER_BITS-1:0] out_winner_q;
	logic                   out_none_q;
	logic                   advance;
	logic                   retire;

	qlmc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	qlmc_pick u_pick (
		.cfg     (cfg),
		.counts  (count_q),
		.quality (quality_s1),
		.pick    (pick)
	);

	always_comb begin
		for (int i = 0; i < qlmc_pkg::SLICE_FIELDS; i++) begin
			quality_in[i] = s_tdata[i*qlmc_pkg::QUALITY_BITS +: qlmc_pkg::QUALITY_BITS];
		end
	end

	// The result register moves on when it is empty or being taken; the word in
	// the input register is decided and retired at that same edge.
	assign advance  = !out_valid_q || m_tready;
	assign retire   = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1     <= s_tuser;
			quality_s1 <= quality_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (retire) begin
			if (cmd_s1 == qlmc_pkg::CMD_CLEAR) begin
				out_winner_q <= '0;
				out_none_q   <= 1'b0;
			end else begin
				// The pick returns slice zero when nothing was found.
				out_winner_q <= pick.winner;
				out_none_q   <= !pick.found;
			end
		end
	end

	// Grant counters: cleared by a clear word, bumped for the winner, and held at
	// all ones so that a count never wraps back below the quota.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (retire) begin
			if (cmd_s1 == qlmc_pkg::CMD_CLEAR) begin
				count_q <= '0;
			end else begin
				for (int i = 0; i < qlmc_pkg::LANES; i++) begin
					if (pick.grant[i] && (count_q[i] != '1)) begin
						count_q[i] <= count_q[i] + qlmc_pkg::COUNT_BITS'(1);
					end
				end
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = qlmc_pkg::TDATA_OUT_BITS'(out_winner_q);
	assign m_tuser  = out_none_q;

	// A clear word leaves every count at zero.
	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		(retire && (cmd_s1 == qlmc_pkg::CMD_CLEAR)) |=> (count_q == '0))
		else $error("grant counts not cleared after a clear word");

	// Counts only move when a word is retired.
	a_counts_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!retire |=> $stable(count_q))
		else $error("grant counts changed without a retired word");

	// Exactly one grant line is raised when a winner is found, none otherwise.
	a_grant_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> ($onehot(pick.grant) == pick.found))
		else $error("grant vector disagrees with the found flag");

	// With a stalled result and a full input register nothing more is taken.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready && valid_s1) |-> !s_tready)
		else $error("input accepted while both registers are full and stalled");

endmodule

// File: dv/tb_quota_limited_max_cqi_slice_arbiter.sv
// Self-checking testbench for the quota-limited max-quality slice arbiter.
// Drives command words and APB register writes, checks every result word.
// Depends on qlmc_pkg and the quota_limited_max_cqi_slice_arbiter top level.
module tb_quota_limited_max_cqi_slice_arbiter;
	timeunit 1ns;
	timeprecision 1ps;

	// Run shape. The quiet phase runs with both sides always ready.
	localparam int RANDOM_PHASES   = 10;
	localparam int WORDS_PER_PHASE = 140;
	localparam int QUIET_PHASE     = 4;
	localparam int IDLE_PCT        = 27;
	localparam int DIRECTED_ROWS   = 30;
	localparam int TAIL_CYCLES     = 8;

	// Register indexes past the end of the map; writes there must be ignored.
	localparam logic [qlmc_pkg::REG_IDX_BITS-1:0] REG_FIRST_UNUSED = 3'd5;
	localparam logic [qlmc_pkg::REG_IDX_BITS-1:0] REG_LAST_UNUSED  = 3'd7;

	typedef enum logic {ROW_WORD, ROW_REG} row_kind_e;

	// One line of the directed table: either a command word or a register write.
	// Where fixed is set, the expected result is typed in rather than predicted.
	typedef struct packed {
		row_kind_e                            kind;
		logic [qlmc_pkg::REG_IDX_BITS-1:0]    reg_idx;
		logic [qlmc_pkg::APB_DATA_BITS-1:0]   reg_val;
		logic                                 cmd;
		logic [qlmc_pkg::TDATA_IN_BITS-1:0]   qual;
		logic                                 fixed;
		logic [qlmc_pkg::WINNER_BITS-1:0]     win;
		logic                                 none;
	} step_row_t;

	typedef struct packed {
		logic [qlmc_pkg::WINNER_BITS-1:0] winner;
		logic                             none;
	} grant_t;

	logic                                 clk;
	logic                                 arst_n;
	logic                                 psel;
	logic                                 penable;
	logic                                 pwrite;
	logic [qlmc_pkg::APB_ADDR_BITS-1:0]   paddr;
	logic [qlmc_pkg::APB_DATA_BITS-1:0]   pwdata;
	logic [qlmc_pkg::APB_DATA_BITS-1:0]   prdata;
	logic                                 pready;
	logic                                 s_tvalid;
	logic                                 s_tready;
	// s_tdata: quality_slice0 [3:0], quality_slice1 [7:4], quality_slice2 [11:8],
	// quality_slice3 [15:12].
	logic [qlmc_pkg::TDATA_IN_BITS-1:0]   s_tdata;
	// s_tuser: cmd [0].
	logic                                 s_tuser;
	logic                                 m_tvalid;
	logic                                 m_tready;
	// m_tdata: winner_slice [1:0], zero fill [7:2].
	logic [qlmc_pkg::TDATA_OUT_BITS-1:0]  m_tdata;
	// m_tuser: none_eligible [0].
	logic                                 m_tuser;

	// The testbench's own copy of the block's configuration and grant counters.
	logic [qlmc_pkg::ACTIVE_BITS-1:0] cfg_active;
	qlmc_pkg::quota_t                 cfg_quota [qlmc_pkg::SLICE_FIELDS];
	qlmc_pkg::count_t                 grant_count [qlmc_pkg::LANES];

	// Results still owed by the block, oldest first.
	grant_t pending_grants [$];
	int     mismatches;
	// Chance in a hundred that the sink idles on a given cycle or the source inserts a gap before a word.
	int     idle_pct;

	quota_limited_max_cqi_slice_arbiter uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// A hard ceiling on the run, far beyond the length of the slowest correct run.
	initial begin
		#2_000_000;
		$display("tb_quota_limited_max_cqi_slice_arbiter NOT OK");
		$finish;
	end

	// Works out the result of one accepted command word and moves the counters on,
	// exactly as the block should. A clear zeroes every counter, inactive slices
	// included. An allocation scans the active lanes; a later lane of equal quality
	// displaces an earlier one, which gives the highest index on a tie, and a
	// quality of zero is as good as any for a lane that is still under quota.
	function automatic grant_t predict_grant(logic cmd,
			logic [qlmc_pkg::TDATA_IN_BITS-1:0] qual);
		grant_t             res;
		int                 lanes;
		int                 best;
		bit                 found;
		qlmc_pkg::quality_t q;
		qlmc_pkg::quality_t best_q;
		res    = '0;
		found  = 1'b0;
		best   = 0;
		best_q = '0;
		if (cmd == qlmc_pkg::CMD_CLEAR) begin
			for (int i = 0; i < qlmc_pkg::LANES; i++)
				grant_count[i] = '0;
			return res;
		end
		// Values above the number of lanes are clamped; zero means nobody takes part.
		lanes = (int'(cfg_active) > qlmc_pkg::LANES) ? qlmc_pkg::LANES : int'(cfg_active);
		for (int i = 0; i < lanes; i++) begin
			q = qual[i*qlmc_pkg::QUALITY_BITS +: qlmc_pkg::QUALITY_BITS];
			if (qlmc_pkg::CMP_BITS'(grant_count[i]) < qlmc_pkg::CMP_BITS'(cfg_quota[i]))
			begin
				if (!found || q >= best_q) begin
					best_q = q;
					best   = i;
					found  = 1'b1;
				end
			end
		end
		if (!found) begin
			// Refused allocation: flag it and leave every counter alone.
			res.none = 1'b1;
			return res;
		end
		if (grant_count[best] != '1)
			grant_count[best] = grant_count[best] + 1'b1;
		res.winner = qlmc_pkg::WINNER_BITS'(best);
		return res;
	endfunction

	function automatic step_row_t item_row(logic cmd,
			logic [qlmc_pkg::TDATA_IN_BITS-1:0] qual);
		step_row_t r;
		r      = '0;
		r.kind = ROW_WORD;
		r.cmd  = cmd;
		r.qual = qual;
		return r;
	endfunction

	function automatic step_row_t fixed_row(logic cmd,
			logic [qlmc_pkg::TDATA_IN_BITS-1:0] qual,
			logic [qlmc_pkg::WINNER_BITS-1:0] win, logic none);
		step_row_t r;
		r       = item_row(cmd, qual);
		r.fixed = 1'b1;
		r.win   = win;
		r.none  = none;
		return r;
	endfunction

	function automatic step_row_t reg_row(logic [qlmc_pkg::REG_IDX_BITS-1:0] idx,
			logic [qlmc_pkg::APB_DATA_BITS-1:0] val);
		step_row_t r;
		r         = '0;
		r.kind    = ROW_REG;
		r.reg_idx = idx;
		r.reg_val = val;
		return r;
	endfunction

	// Offers one command word and holds it until the block takes it. Called at a
	// rising edge, it returns at the edge of acceptance, where the expectation is
	// queued. The valid line is only lowered when a gap is inserted, so in no time
	// step is it both lowered and raised.
	task automatic send_word(input step_row_t row);
		grant_t want;
		if ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= row.cmd;
		s_tdata  <= row.qual;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		want = predict_grant(row.cmd, row.qual);
		if (row.fixed)
			want = '{winner: row.win, none: row.none};
		pending_grants = {pending_grants, want};
	endtask

	// Lets the stream run dry: every accepted word has an expectation, so an empty
	// queue means the block holds no more work.
	task automatic drain_stream();
		s_tvalid <= 1'b0;
		while (pending_grants.size() != 0)
			@(posedge clk);
	endtask

	// APB write: setup, then access. The register takes the value at the edge where
	// the access phase meets pready, and so does our copy of it. Bits above the
	// register's width are dropped, and unused indexes are ignored. psel is then
	// lowered before returning, so back-to-back writes never drive psel twice at once.
	task automatic apb_write(input logic [qlmc_pkg::REG_IDX_BITS-1:0] idx,
			input logic [qlmc_pkg::APB_DATA_BITS-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
			qlmc_pkg::REG_ACTIVE: cfg_active   = val[qlmc_pkg::ACTIVE_BITS-1:0];
			qlmc_pkg::REG_QUOTA0: cfg_quota[0] = val[qlmc_pkg::QUOTA_BITS-1:0];
			qlmc_pkg::REG_QUOTA1: cfg_quota[1] = val[qlmc_pkg::QUOTA_BITS-1:0];
			qlmc_pkg::REG_QUOTA2: cfg_quota[2] = val[qlmc_pkg::QUOTA_BITS-1:0];
			qlmc_pkg::REG_QUOTA3: cfg_quota[3] = val[qlmc_pkg::QUOTA_BITS-1:0];
			default: ;
		endcase
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Result side: compares each accepted result word with the oldest expectation
	// and throttles m_tready at random. Values are read just after the edge, before
	// any update scheduled at that edge has landed.
	initial begin
		grant_t want;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				if (pending_grants.size() == 0) begin
					$display({"%0t: unexpected result word, expected none, ",
						"actual winner_slice %0d none_eligible %0d"},
						$time, m_tdata[qlmc_pkg::WINNER_BITS-1:0], m_tuser);
					mismatches++;
				end else begin
					want = pending_grants.pop_front();
					if (m_tdata[qlmc_pkg::WINNER_BITS-1:0] !== want.winner) begin
						$display("%0t: winner_slice expected %0d actual %0d",
							$time, want.winner, m_tdata[qlmc_pkg::WINNER_BITS-1:0]);
						mismatches++;
					end
					if (m_tuser !== want.none) begin
						$display("%0t: none_eligible expected %0d actual %0d",
							$time, want.none, m_tuser);
						mismatches++;
					end
				end
			end
			m_tready <= ($urandom_range(0, 99) >= idle_pct);
		end
	end

	initial begin
		step_row_t                          rows [DIRECTED_ROWS];
		logic [qlmc_pkg::APB_DATA_BITS-1:0] val;
		logic [qlmc_pkg::ACTIVE_BITS-1:0]   active;
		logic [qlmc_pkg::TDATA_IN_BITS-1:0] qual;
		logic                               cmd;

		mismatches = 0;
		idle_pct   = IDLE_PCT;
		cfg_active = qlmc_pkg::ACTIVE_RESET;
		for (int i = 0; i < qlmc_pkg::SLICE_FIELDS; i++)
			cfg_quota[i] = qlmc_pkg::QUOTA_RESET;
		for (int i = 0; i < qlmc_pkg::LANES; i++)
			grant_count[i] = '0;

		arst_n   <= 1'b0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= qlmc_pkg::CMD_CLEAR;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Qualities read as {slice3, slice2, slice1, slice0}.
		rows = '{
			// Reset settings: four slices, quota eight each.
			fixed_row(qlmc_pkg::CMD_CLEAR, 16'h0000, 2'd0, 1'b0),
			// All qualities zero: every slice qualifies, the highest index wins.
			fixed_row(qlmc_pkg::CMD_ALLOC, 16'h0000, 2'd3, 1'b0),
			fixed_row(qlmc_pkg::CMD_ALLOC, 16'hFFFF, 2'd3, 1'b0),
			fixed_row(qlmc_pkg::CMD_ALLOC, 16'h000F, 2'd0, 1'b0),
			fixed_row(qlmc_pkg::CMD_ALLOC, 16'h00F0, 2'd1, 1'b0),
			fixed_row(qlmc_pkg::CMD_ALLOC, 16'h0F00, 2'd2, 1'b0),
			fixed_row(qlmc_pkg::CMD_ALLOC, 16'hF000, 2'd3, 1'b0),
			item_row(qlmc_pkg::CMD_ALLOC, 16'hA3A5),
			// Active count of zero, with junk above the field: nobody takes part.
			reg_row(qlmc_pkg::REG_ACTIVE, 32'hFFFF_FFF8),
			fixed_row(qlmc_pkg::CMD_ALLOC, 16'hFFFF, 2'd0, 1'b1),
			// Active count above four is clamped; quotas at both extremes.
			reg_row(qlmc_pkg::REG_ACTIVE, 32'd7),
			reg_row(qlmc_pkg::REG_QUOTA0, 32'd1),
			reg_row(qlmc_pkg::REG_QUOTA1, 32'd0),
			reg_row(qlmc_pkg::REG_QUOTA2, 32'd2),
			reg_row(qlmc_pkg::REG_QUOTA3, 32'd63),
			reg_row(REG_FIRST_UNUSED, 32'hFFFF_FFFF),
			fixed_row(qlmc_pkg::CMD_CLEAR, 16'hFFFF, 2'd0, 1'b0),
			fixed_row(qlmc_pkg::CMD_ALLOC, 16'h000F, 2'd0, 1'b0),
			// Slice zero now at quota and slice one never eligible.
			item_row(qlmc_pkg::CMD_ALLOC, 16'h000F),
			item_row(qlmc_pkg::CMD_ALLOC, 16'h0900),
			item_row(qlmc_pkg::CMD_ALLOC, 16'h0900),
			item_row(qlmc_pkg::CMD_ALLOC, 16'h0900),
			// A single slice that runs out of quota within the interval.
			reg_row(qlmc_pkg::REG_ACTIVE, 32'd1),
			reg_row(qlmc_pkg::REG_QUOTA0, 32'd2),
			fixed_row(qlmc_pkg::CMD_CLEAR, 16'h0000, 2'd0, 1'b0),
			fixed_row(qlmc_pkg::CMD_ALLOC, 16'hF000, 2'd0, 1'b0),
			fixed_row(qlmc_pkg::CMD_ALLOC, 16'h0000, 2'd0, 1'b0),
			fixed_row(qlmc_pkg::CMD_ALLOC, 16'hFFFF, 2'd0, 1'b1),
			fixed_row(qlmc_pkg::CMD_CLEAR, 16'h5A5A, 2'd0, 1'b0),
			fixed_row(qlmc_pkg::CMD_ALLOC, 16'h1234, 2'd0, 1'b0)
		};
		foreach (rows[i]) begin
			if (rows[i].kind == ROW_REG) begin
				drain_stream();
				apb_write(rows[i].reg_idx, rows[i].reg_val);
			end else begin
				send_word(rows[i]);
			end
		end

		// Random part. Each phase starts from an idle block with fresh settings,
		// mostly small quotas so that slices run out between clears, with the odd
		// zero or full-scale quota and out-of-range active counts.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			drain_stream();
			case ($urandom_range(0, 9))
				0: active = '0;
				1: active = qlmc_pkg::ACTIVE_BITS'($urandom_range(5, 7));
				default: active = qlmc_pkg::ACTIVE_BITS'($urandom_range(1, 4));
			endcase
			val = $urandom();
			val[qlmc_pkg::ACTIVE_BITS-1:0] = active;
			apb_write(qlmc_pkg::REG_ACTIVE, val);
			for (int i = 0; i < qlmc_pkg::SLICE_FIELDS; i++) begin
				val = $urandom();
				case ($urandom_range(0, 9))
					0: val[qlmc_pkg::QUOTA_BITS-1:0] = '0;
					1: val[qlmc_pkg::QUOTA_BITS-1:0] = '1;
					default: val[qlmc_pkg::QUOTA_BITS-1:0] =
						qlmc_pkg::QUOTA_BITS'($urandom_range(1, 10));
				endcase
				apb_write(qlmc_pkg::REG_QUOTA0 + qlmc_pkg::REG_IDX_BITS'(i), val);
			end
			apb_write(qlmc_pkg::REG_IDX_BITS'($urandom_range(int'(REG_FIRST_UNUSED),
				int'(REG_LAST_UNUSED))), $urandom());

			// One phase runs flat out on both sides.
			idle_pct = (phase == QUIET_PHASE) ? 0 : IDLE_PCT;
			for (int n = 0; n < WORDS_PER_PHASE; n++) begin
				cmd  = ($urandom_range(0, 11) == 0) ? qlmc_pkg::CMD_CLEAR
					: qlmc_pkg::CMD_ALLOC;
				qual = qlmc_pkg::TDATA_IN_BITS'($urandom());
				// Squeeze the qualities now and then so that ties are common.
				if ($urandom_range(0, 3) == 0)
					qual = qual & 16'h1111;
				send_word(item_row(cmd, qual));
			end
		end

		drain_stream();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb_quota_limited_max_cqi_slice_arbiter OK");
		else
			$display("tb_quota_limited_max_cqi_slice_arbiter NOT OK");
		$finish;
	end

endmodule
